// File: rtl/hcmm_pkg.sv
// Shared constants and types for the handheld console memory map decoder.
package hcmm_pkg;

    // Fixed store sizes and field widths
    localparam int WORK_RAM_BYTES_DEFAULT = 32768;
    localparam int HIGH_RAM_BYTES = 128;
    localparam int UNUSED_BYTES   = 96;
    localparam int UNUSED_ROWS    = 16;
    localparam int UNUSED_COLS    = UNUSED_BYTES / UNUSED_ROWS;
    localparam int ADDR_W         = 16;
    localparam int DATA_W         = 8;
    localparam int CFG_DATA_W     = 3;

    // Request opcode
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic REG_WORK_RAM_BANK  = 1'b0;
    localparam logic REG_VIDEO_RAM_BANK = 1'b1;

    // Destination of a decoded request
    typedef enum logic [2:0] {
        TGT_HERE = 3'd0,
        TGT_BOOT = 3'd1,
        TGT_CART = 3'd2,
        TGT_VRAM = 3'd3,
        TGT_OAM  = 3'd4,
        TGT_IO   = 3'd5
    } target_t;

    // Source of the local read byte
    typedef enum logic [1:0] {
        SRC_CONST  = 2'd0,
        SRC_WRAM   = 2'd1,
        SRC_HRAM   = 2'd2,
        SRC_UNUSED = 2'd3
    } read_src_t;

endpackage

// File: rtl/handheld_console_memory_map.sv
// Top level: memory map decoder with local work RAM, high RAM and unused-area stores.
//
//  channel   | handshake            | signals
//  ----------+----------------------+------------------------------------------------
//  request   | start / busy         | opcode, address, write_data, dma_active,
//            |                      | video_ram_locked, object_ram_locked, pc_at_boot_end
//  result    | done (one cycle)     | target, target_offset, forward_data,
//            |                      | forward_write, read_data
//  config    | write_enable         | register_index, register_data
//
// A request is decoded in its accept cycle; stores are written at the accept edge and
// read through the registered synchronous port, so done follows in the next cycle.
// A new request may be accepted every cycle while busy is low; the single memory port per store sets this.
// After reset a clearing pass zeroes every store, one work RAM entry per cycle; busy is
// high meanwhile. Config writes are taken at any time.
// The result receiver cannot stall; each result is shown for exactly one cycle.
module handheld_console_memory_map
    import hcmm_pkg::*;
#(
    parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  opcode,
    input  logic [ADDR_W-1:0]     address,
    input  logic [DATA_W-1:0]     write_data,
    input  logic                  dma_active,
    input  logic                  video_ram_locked,
    input  logic                  object_ram_locked,
    input  logic                  pc_at_boot_end,
    output logic                  done,
    output logic [2:0]            target,
    output logic [ADDR_W-1:0]     target_offset,
    output logic [DATA_W-1:0]     forward_data,
    output logic                  forward_write,
    output logic [DATA_W-1:0]     read_data,
    input  logic                  write_enable,
    input  logic                  register_index,
    input  logic [CFG_DATA_W-1:0] register_data
);

    localparam int                WRAM_AW   = $clog2(WORK_RAM_BYTES);
    localparam logic [ADDR_W-1:0] WRAM_SIZE = ADDR_W'(WORK_RAM_BYTES);
    localparam logic [WRAM_AW-1:0] CLEAR_LAST = WRAM_AW'(WORK_RAM_BYTES - 1);
    localparam int                HRAM_AW   = $clog2(HIGH_RAM_BYTES);
    localparam int                ROW_AW    = $clog2(UNUSED_ROWS);
    localparam int                COL_AW    = $clog2(UNUSED_COLS);

    // Stores
    logic [DATA_W-1:0]                  work_ram [WORK_RAM_BYTES];
    logic [DATA_W-1:0]                  high_ram [HIGH_RAM_BYTES];
    logic [UNUSED_COLS-1:0][DATA_W-1:0] unused_ram [UNUSED_ROWS];

    // Control and state registers
    logic                 clearing_reg;
    logic [WRAM_AW-1:0]   clear_count_reg;
    logic [2:0]           wram_bank_reg;
    logic                 vram_bank_reg;
    logic [DATA_W-1:0]    ie_reg, ie_next;
    logic                 boot_mapped_reg, boot_mapped_next;
    logic                 done_reg;

    // Result registers
    target_t              target_reg, target_next;
    logic [ADDR_W-1:0]    offset_reg, offset_next;
    logic [DATA_W-1:0]    fwd_data_reg;
    logic                 fwd_write_reg, fwd_write_next;
    logic [DATA_W-1:0]    const_reg, const_next;
    read_src_t            src_reg, src_next;
    logic [COL_AW-1:0]    col_reg;

    // Read data from the stores
    logic [DATA_W-1:0]                  wram_q;
    logic [DATA_W-1:0]                  hram_q;
    logic [UNUSED_COLS-1:0][DATA_W-1:0] unused_q;

    // Decode signals
    logic                 accept;
    logic                 wram_we, hram_we;
    logic [UNUSED_COLS-1:0] unused_be;
    logic [WRAM_AW-1:0]   wram_idx;
    logic [HRAM_AW-1:0]   hram_idx;
    logic [7:0]           unused_idx;
    logic [ROW_AW-1:0]    unused_row;
    logic [COL_AW-1:0]    unused_col;

    // Work RAM index: bank offset above D000, wrapped to the store size
    function automatic logic [WRAM_AW-1:0] wram_index(input logic [ADDR_W-1:0] addr,
                                                      input logic [2:0] bank);
        logic [ADDR_W-1:0] sum;
        sum = {3'b000, addr[12:0]};
        if (addr[12])
        begin
            sum = sum + {1'b0, bank, 12'h000};
        end
        for (int k = 0; k < 4; k++)
        begin
            if (sum >= WRAM_SIZE)
            begin
                sum = sum - WRAM_SIZE;
            end
        end
        return sum[WRAM_AW-1:0];
    endfunction

    assign accept     = start && !clearing_reg;
    assign busy       = clearing_reg;
    assign wram_idx   = wram_index(address, wram_bank_reg);
    assign hram_idx   = address[HRAM_AW-1:0];
    assign unused_idx = address[7:0] - 8'hA0;
    assign unused_row = unused_idx[ROW_AW-1:0];
    assign unused_col = unused_idx[ROW_AW+COL_AW-1:ROW_AW];

    // Decode one request
    always_comb
    begin
        target_next      = TGT_HERE;
        offset_next      = '0;
        fwd_write_next   = 1'b0;
        const_next       = '0;
        src_next         = SRC_CONST;
        ie_next          = ie_reg;
        boot_mapped_next = boot_mapped_reg;
        wram_we          = 1'b0;
        hram_we          = 1'b0;
        unused_be        = '0;
        if (opcode == OP_WRITE)
        begin
            if (dma_active && address < 16'hFF80)
            begin
                // drop writes below FF80 while DMA runs
            end
            else if (address inside {[16'h0000:16'h7FFF]})
            begin
                if (!boot_mapped_reg)
                begin
                    target_next    = TGT_CART;
                    offset_next    = address;
                    fwd_write_next = 1'b1;
                end
            end
            else if (address inside {[16'h8000:16'h9FFF]})
            begin
                if (!video_ram_locked)
                begin
                    target_next    = TGT_VRAM;
                    offset_next    = {2'b00, vram_bank_reg, address[12:0]};
                    fwd_write_next = 1'b1;
                end
            end
            else if (address inside {[16'hA000:16'hBFFF]})
            begin
                target_next    = TGT_CART;
                offset_next    = address;
                fwd_write_next = 1'b1;
            end
            else if (address inside {[16'hC000:16'hDFFF]})
            begin
                wram_we = 1'b1;
            end
            else if (address inside {[16'hE000:16'hFDFF]})
            begin
                // echo RAM ignores writes
            end
            else if (address inside {[16'hFE00:16'hFE9F]})
            begin
                if (!object_ram_locked)
                begin
                    target_next    = TGT_OAM;
                    offset_next    = address - 16'hFE00;
                    fwd_write_next = 1'b1;
                end
            end
            else if (address inside {[16'hFEA0:16'hFEFF]})
            begin
                // mirror the upper half into four groups of sixteen
                if (address >= 16'hFEC0)
                begin
                    unused_be = UNUSED_COLS'(6'b111100);
                end
                else
                begin
                    unused_be[unused_col] = 1'b1;
                end
            end
            else if (address inside {[16'hFF00:16'hFF7F]})
            begin
                target_next    = TGT_IO;
                offset_next    = address - 16'hFF00;
                fwd_write_next = 1'b1;
            end
            else if (address inside {[16'hFF80:16'hFFFE]})
            begin
                hram_we = 1'b1;
            end
            else
            begin
                ie_next = write_data;
            end
        end
        else
        begin
            if (address inside {[16'h0000:16'h7FFF]})
            begin
                offset_next = address;
                if (boot_mapped_reg && address < 16'h0100)
                begin
                    target_next = TGT_BOOT;
                end
                else
                begin
                    target_next = TGT_CART;
                    if (boot_mapped_reg && pc_at_boot_end)
                    begin
                        boot_mapped_next = 1'b0;
                    end
                end
            end
            else if (address inside {[16'h8000:16'h9FFF]})
            begin
                if (video_ram_locked)
                begin
                    const_next = 8'hFF;
                end
                else
                begin
                    target_next = TGT_VRAM;
                    offset_next = {2'b00, vram_bank_reg, address[12:0]};
                end
            end
            else if (address inside {[16'hA000:16'hBFFF]})
            begin
                target_next = TGT_CART;
                offset_next = address;
            end
            else if (address inside {[16'hC000:16'hDFFF]})
            begin
                src_next = SRC_WRAM;
            end
            else if (address inside {[16'hE000:16'hFDFF]})
            begin
                const_next = '0;
            end
            else if (address inside {[16'hFE00:16'hFE9F]})
            begin
                if (object_ram_locked)
                begin
                    const_next = 8'hFF;
                end
                else
                begin
                    target_next = TGT_OAM;
                    offset_next = address - 16'hFE00;
                end
            end
            else if (address inside {[16'hFEA0:16'hFEFF]})
            begin
                src_next = SRC_UNUSED;
            end
            else if (address inside {[16'hFF00:16'hFF7F]})
            begin
                target_next = TGT_IO;
                offset_next = address - 16'hFF00;
            end
            else if (address inside {[16'hFF80:16'hFFFE]})
            begin
                src_next = SRC_HRAM;
            end
            else
            begin
                const_next = ie_reg;
            end
        end
    end

    // Control state: clearing pass, config, boot ROM map, interrupt enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg    <= 1'b1;
            clear_count_reg <= '0;
            wram_bank_reg   <= '0;
            vram_bank_reg   <= 1'b0;
            ie_reg          <= '0;
            boot_mapped_reg <= 1'b1;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clear_count_reg <= clear_count_reg + 1'b1;
                if (clear_count_reg == CLEAR_LAST)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (write_enable)
            begin
                case (register_index)
                    REG_WORK_RAM_BANK:  wram_bank_reg <= register_data;
                    REG_VIDEO_RAM_BANK: vram_bank_reg <= register_data[0];
                    default:            ;
                endcase
            end
            if (accept)
            begin
                ie_reg          <= ie_next;
                boot_mapped_reg <= boot_mapped_next;
            end
            done_reg <= accept;
        end
    end

    // Register the decoded result on accept and hold it until the next accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg    <= target_next;
            offset_reg    <= offset_next;
            fwd_write_reg <= fwd_write_next;
            fwd_data_reg  <= fwd_write_next ? write_data : '0;
            const_reg     <= const_next;
            src_reg       <= (opcode == OP_WRITE) ? SRC_CONST : src_next;
            col_reg       <= unused_col;
        end
    end

    // Work RAM: clear sweep or request write, registered read
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            work_ram[clear_count_reg] <= '0;
        end
        else if (accept && wram_we)
        begin
            work_ram[wram_idx] <= write_data;
        end
        wram_q <= work_ram[wram_idx];
    end

    // High RAM: cleared alongside the work RAM sweep
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            high_ram[clear_count_reg[HRAM_AW-1:0]] <= '0;
        end
        else if (accept && hram_we)
        begin
            high_ram[hram_idx] <= write_data;
        end
        hram_q <= high_ram[hram_idx];
    end

    // Unused area: sixteen rows of six byte lanes with byte enables
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            unused_ram[clear_count_reg[ROW_AW-1:0]] <= '0;
        end
        else if (accept)
        begin
            for (int c = 0; c < UNUSED_COLS; c++)
            begin
                if (unused_be[c])
                begin
                    unused_ram[unused_row][c] <= write_data;
                end
            end
        end
        unused_q <= unused_ram[unused_row];
    end

    // Drive the result
    always_comb
    begin
        case (src_reg)
            SRC_WRAM:   read_data = wram_q;
            SRC_HRAM:   read_data = hram_q;
            SRC_UNUSED: read_data = unused_q[col_reg];
            default:    read_data = const_reg;
        endcase
    end

    assign done          = done_reg;
    assign target        = target_reg;
    assign target_offset = offset_reg;
    assign forward_data  = fwd_data_reg;
    assign forward_write = fwd_write_reg;

    // A result only follows an accepted request
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without accepted request");

    // Forwarded writes only go to writable targets
    a_fwd_target: assert property (@(posedge clk) disable iff (!rst_n)
        done && forward_write |-> target != TGT_HERE && target != TGT_BOOT)
        else $error("forwarded write to local or boot target");

    // Forwarded requests carry no local read byte
    a_fwd_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && target != TGT_HERE |-> read_data == '0)
        else $error("read byte on forwarded request");

endmodule
